>>> hdl/ean13_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean13_pkg
// Shared types, code tables and segment constants for the EAN-13 encoder.
// ----------------------------------------------------------------------------
package ean13_pkg;

   localparam int DIGIT_WIDTH       = 4;
   localparam int NUM_DIGITS        = 13;
   localparam int CODE_WIDTH        = DIGIT_WIDTH * NUM_DIGITS;
   localparam int NUM_LANES         = 12;
   localparam int LANES_PER_HALF    = NUM_LANES / 2;
   localparam int LANE_INDEX_WIDTH  = 4;
   localparam int PATTERN_WIDTH     = 7;
   localparam int COUNT_WIDTH       = 5;
   localparam int SEG_INDEX_WIDTH   = 5;
   localparam int CSR_INDEX_WIDTH   = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_QUIET  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_QUIET = 2'd1;

   localparam logic [COUNT_WIDTH-1:0] LEFT_QUIET_RESET  = 5'd11;
   localparam logic [COUNT_WIDTH-1:0] RIGHT_QUIET_RESET = 5'd7;

   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_LEFT_QUIET  = 5'd0;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_START_GUARD = 5'd1;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_LEFT_FIRST  = 5'd2;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_LEFT_LAST   = 5'd7;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_CENTER      = 5'd8;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_RIGHT_LAST  = 5'd14;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_END_GUARD   = 5'd15;
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_RIGHT_QUIET = 5'd16;
   // right lanes sit one segment further on, past the center guard
   localparam logic [SEG_INDEX_WIDTH-1:0] SEG_RIGHT_OFFSET = 5'd3;

   localparam logic [PATTERN_WIDTH-1:0] EDGE_GUARD_PATTERN   = 7'h50;
   localparam logic [PATTERN_WIDTH-1:0] CENTER_GUARD_PATTERN = 7'h28;
   localparam logic [PATTERN_WIDTH-1:0] QUIET_PATTERN        = 7'h00;

   localparam logic [COUNT_WIDTH-1:0] EDGE_GUARD_COUNT   = 5'd3;
   localparam logic [COUNT_WIDTH-1:0] CENTER_GUARD_COUNT = 5'd5;
   localparam logic [COUNT_WIDTH-1:0] DIGIT_COUNT        = 5'd7;

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX = 4'd9;

   typedef struct packed {
      logic right;
      logic use_l;
      logic lead_ok;
   } lane_mode_type;

   typedef struct packed {
      logic [PATTERN_WIDTH-1:0] pattern;
      logic                     error;
   } lane_result_type;

   function automatic logic [5:0] parity_lookup(input logic [DIGIT_WIDTH-1:0] lead);
      logic [5:0] p;
      case (lead)
         4'd0:    p = 6'h3F;
         4'd1:    p = 6'h34;
         4'd2:    p = 6'h32;
         4'd3:    p = 6'h31;
         4'd4:    p = 6'h2C;
         4'd5:    p = 6'h26;
         4'd6:    p = 6'h23;
         4'd7:    p = 6'h2A;
         4'd8:    p = 6'h29;
         4'd9:    p = 6'h25;
         default: p = 6'h00;
      endcase
      return p;
   endfunction

   function automatic logic [PATTERN_WIDTH-1:0] l_code(input logic [DIGIT_WIDTH-1:0] d);
      logic [PATTERN_WIDTH-1:0] c;
      case (d)
         4'd0:    c = 7'h0D;
         4'd1:    c = 7'h19;
         4'd2:    c = 7'h13;
         4'd3:    c = 7'h3D;
         4'd4:    c = 7'h23;
         4'd5:    c = 7'h31;
         4'd6:    c = 7'h2F;
         4'd7:    c = 7'h3B;
         4'd8:    c = 7'h37;
         4'd9:    c = 7'h0B;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [PATTERN_WIDTH-1:0] reverse7(input logic [PATTERN_WIDTH-1:0] v);
      logic [PATTERN_WIDTH-1:0] r;
      for (int i = 0; i < PATTERN_WIDTH; i++) begin
         r[i] = v[PATTERN_WIDTH-1-i];
      end
      return r;
   endfunction

endpackage

>>> hdl/ean13_digit_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean13_digit_lane
// Encodes one digit into its 7-module L, G or R pattern.
// ----------------------------------------------------------------------------
module ean13_digit_lane (
   input  logic [ean13_pkg::DIGIT_WIDTH-1:0] digit,
   input  ean13_pkg::lane_mode_type          mode,
   output ean13_pkg::lane_result_type        result
);

   logic [ean13_pkg::PATTERN_WIDTH-1:0] l_pat;
   logic [ean13_pkg::PATTERN_WIDTH-1:0] r_pat;
   logic                                bad;

   always_comb begin
      l_pat = ean13_pkg::l_code(digit);
      r_pat = ~l_pat;
      bad   = (digit > ean13_pkg::DIGIT_MAX) || (!mode.right && !mode.lead_ok);
      result.error = bad;
      if (bad) begin
         result.pattern = ean13_pkg::QUIET_PATTERN;
      end else if (mode.right) begin
         result.pattern = r_pat;
      end else if (mode.use_l) begin
         result.pattern = l_pat;
      end else begin
         result.pattern = ean13_pkg::reverse7(r_pat);   // G code
      end
   end

endmodule

>>> hdl/ean13_segment_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean13_segment_merge
// Holds the twelve lane results of one code and sends the 17 segments out,
// guards and quiet zones merged in, one transfer per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module ean13_segment_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load_valid,
   input  ean13_pkg::lane_result_type            load_lanes [ean13_pkg::NUM_LANES],
   output logic                                  load_take,
   input  logic [ean13_pkg::COUNT_WIDTH-1:0]     left_quiet,
   input  logic [ean13_pkg::COUNT_WIDTH-1:0]     right_quiet,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ean13_pkg::PATTERN_WIDTH-1:0]   rsp_pattern,
   output logic [ean13_pkg::COUNT_WIDTH-1:0]     rsp_module_count,
   output logic                                  rsp_digit_error,
   output logic                                  rsp_last
);

   ean13_pkg::lane_result_type                lanes_ff [ean13_pkg::NUM_LANES];
   logic                                      busy_ff;
   logic [ean13_pkg::SEG_INDEX_WIDTH-1:0]     idx_ff;
   logic                                      valid_ff;
   logic [ean13_pkg::PATTERN_WIDTH-1:0]       pattern_ff;
   logic [ean13_pkg::COUNT_WIDTH-1:0]         count_ff;
   logic                                      error_ff;
   logic                                      last_ff;

   logic                                      advance;
   logic                                      final_seg;
   logic [ean13_pkg::LANE_INDEX_WIDTH-1:0]    lane_sel;
   logic [ean13_pkg::SEG_INDEX_WIDTH-1:0]     lane_off;
   ean13_pkg::lane_result_type                lane_pick;
   logic [ean13_pkg::PATTERN_WIDTH-1:0]       pattern_in;
   logic [ean13_pkg::COUNT_WIDTH-1:0]         count_in;
   logic                                      error_in;
   logic                                      last_in;

   assign advance   = !valid_ff || !rsp_stall;
   assign final_seg = (idx_ff == ean13_pkg::SEG_RIGHT_QUIET);
   assign load_take = advance && (!busy_ff || final_seg);

   always_comb begin
      if (idx_ff <= ean13_pkg::SEG_LEFT_LAST) begin
         lane_off = idx_ff - ean13_pkg::SEG_LEFT_FIRST;
      end else begin
         lane_off = idx_ff - ean13_pkg::SEG_RIGHT_OFFSET;
      end
      lane_sel  = lane_off[ean13_pkg::LANE_INDEX_WIDTH-1:0];
      lane_pick = lanes_ff[lane_sel];

      pattern_in = ean13_pkg::QUIET_PATTERN;
      count_in   = ean13_pkg::DIGIT_COUNT;
      error_in   = 1'b0;
      last_in    = 1'b0;
      if (idx_ff == ean13_pkg::SEG_LEFT_QUIET) begin
         count_in = left_quiet;
      end else if (idx_ff == ean13_pkg::SEG_START_GUARD ||
                   idx_ff == ean13_pkg::SEG_END_GUARD) begin
         pattern_in = ean13_pkg::EDGE_GUARD_PATTERN;
         count_in   = ean13_pkg::EDGE_GUARD_COUNT;
      end else if (idx_ff == ean13_pkg::SEG_CENTER) begin
         pattern_in = ean13_pkg::CENTER_GUARD_PATTERN;
         count_in   = ean13_pkg::CENTER_GUARD_COUNT;
      end else if (idx_ff <= ean13_pkg::SEG_RIGHT_LAST) begin
         pattern_in = lane_pick.pattern;
         error_in   = lane_pick.error;
      end else begin
         count_in = right_quiet;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= ean13_pkg::SEG_LEFT_QUIET;
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= busy_ff;
         if (busy_ff) begin
            pattern_ff <= pattern_in;
            count_ff   <= count_in;
            error_ff   <= error_in;
            last_ff    <= last_in;
         end
         if (load_take && load_valid) begin
            busy_ff  <= 1'b1;
            idx_ff   <= ean13_pkg::SEG_LEFT_QUIET;
            lanes_ff <= load_lanes;
         end else if (busy_ff) begin
            if (final_seg) begin
               busy_ff <= 1'b0;
               idx_ff  <= ean13_pkg::SEG_LEFT_QUIET;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pattern      = pattern_ff;
   assign rsp_module_count = count_ff;
   assign rsp_digit_error  = error_ff;
   assign rsp_last         = last_ff;

endmodule

>>> hdl/ean13_symbol_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean13_symbol_encoder
// EAN-13 encoder: one packed BCD code in, 17 module segments out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    req_code_digits[51:0]
//  rsp      out  rsp_valid/stall    pattern, module_count, digit_error, last
//  csr      in   csr_valid/ready    csr_index[1:0], csr_data[4:0]
//
//  Twelve digit lanes encode a code in the cycle it is taken into a one-entry
//  buffer; the segment stage sends 17 transfers, one per cycle while rsp_stall
//  is low, and the buffer takes the next code while the stage sends the last.
//  Codes pass the buffer, lane registers and output register; rsp_stall holds
//  the output register and stalls the segment stage; req_stall is high while the
//  buffer is full. Reset is synchronous; quiet zones return to 11 and 7 modules.
// ----------------------------------------------------------------------------
module ean13_symbol_encoder (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ean13_pkg::CODE_WIDTH-1:0]        req_code_digits,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ean13_pkg::PATTERN_WIDTH-1:0]     rsp_pattern,
   output logic [ean13_pkg::COUNT_WIDTH-1:0]       rsp_module_count,
   output logic                                    rsp_digit_error,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ean13_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ean13_pkg::COUNT_WIDTH-1:0]       csr_data
);

   logic [ean13_pkg::COUNT_WIDTH-1:0]   left_quiet_ff;
   logic [ean13_pkg::COUNT_WIDTH-1:0]   right_quiet_ff;

   ean13_pkg::lane_result_type          lane_out [ean13_pkg::NUM_LANES];
   ean13_pkg::lane_result_type          buf_ff   [ean13_pkg::NUM_LANES];
   logic                                buf_valid_ff;
   logic                                load_take;
   logic                                req_take;

   logic [ean13_pkg::DIGIT_WIDTH-1:0]   lead;
   logic                                lead_ok;
   logic [5:0]                          parity;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_quiet_ff  <= ean13_pkg::LEFT_QUIET_RESET;
         right_quiet_ff <= ean13_pkg::RIGHT_QUIET_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ean13_pkg::CSR_LEFT_QUIET) begin
            left_quiet_ff <= csr_data;
         end else if (csr_index == ean13_pkg::CSR_RIGHT_QUIET) begin
            right_quiet_ff <= csr_data;
         end
      end
   end

   assign lead    = req_code_digits[ean13_pkg::CODE_WIDTH-1 -: ean13_pkg::DIGIT_WIDTH];
   assign lead_ok = (lead <= ean13_pkg::DIGIT_MAX);
   assign parity  = ean13_pkg::parity_lookup(lead);

   for (genvar i = 0; i < ean13_pkg::NUM_LANES; i++) begin : g_lane
      ean13_pkg::lane_mode_type mode;
      if (i < ean13_pkg::LANES_PER_HALF) begin : g_left
         assign mode.right = 1'b0;
         assign mode.use_l = parity[ean13_pkg::LANES_PER_HALF-1-i];
      end else begin : g_right
         assign mode.right = 1'b1;
         assign mode.use_l = 1'b0;
      end
      assign mode.lead_ok = lead_ok;

      ean13_digit_lane u_lane (
         .digit  (req_code_digits[ean13_pkg::DIGIT_WIDTH*(ean13_pkg::NUM_LANES-1-i)
                                  +: ean13_pkg::DIGIT_WIDTH]),
         .mode   (mode),
         .result (lane_out[i])
      );
   end

   assign req_stall = buf_valid_ff;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req_take) begin
         buf_valid_ff <= 1'b1;
      end else if (load_take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         buf_ff <= lane_out;
      end
   end

   ean13_segment_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (buf_valid_ff),
      .load_lanes       (buf_ff),
      .load_take        (load_take),
      .left_quiet       (left_quiet_ff),
      .right_quiet      (right_quiet_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern      (rsp_pattern),
      .rsp_module_count (rsp_module_count),
      .rsp_digit_error  (rsp_digit_error),
      .rsp_last         (rsp_last)
   );

endmodule
